/* sv/uhcr_pkg.sv */
`timescale 1ns / 1ps
package uhcr_pkg;

  localparam int unsigned PktBytes   = 32;  // control endpoint packet size
  localparam int unsigned MaxChunks  = 8;   // maximum results per descriptor request
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned ChunkIdxW = $clog2(MaxChunks);
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_SETUP       = 2'd0,
    OP_BUS_RESET   = 2'd1,
    OP_FRAME       = 2'd2,
    OP_REPORT_SENT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_STALL  = 3'd1,
    ACT_ACK    = 3'd2,
    ACT_DESC   = 3'd3,
    ACT_BYTES  = 3'd4,
    ACT_REPORT = 3'd5,
    ACT_IDLE   = 3'd6,
    ACT_ADDR   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    CFG_REPORT_LEN  = 2'd0,
    CFG_VENDOR_LEN  = 2'd1,
    CFG_PRODUCT_LEN = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  // request codes
  localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC      = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
  localparam logic [7:0] CLS_FETCH_REPORT  = 8'd1;
  localparam logic [7:0] CLS_FETCH_RATE    = 8'd2;
  localparam logic [7:0] CLS_FETCH_MODE    = 8'd3;
  localparam logic [7:0] CLS_STORE_REPORT  = 8'd9;
  localparam logic [7:0] CLS_STORE_RATE    = 8'd10;
  localparam logic [7:0] CLS_STORE_MODE    = 8'd11;

  // request types
  localparam logic [7:0] RT_STD_OUT   = 8'h00;
  localparam logic [7:0] RT_STD_IN    = 8'h80;
  localparam logic [7:0] RT_CLASS_IN  = 8'ha1;
  localparam logic [7:0] RT_CLASS_OUT = 8'h21;

  localparam logic [7:0] IdleRateReset     = 8'd125;
  localparam logic [7:0] ProtocolReset     = 8'd1;
  localparam logic [7:0] ReportLenReset    = 8'd63;
  localparam logic [7:0] VendorLenReset    = 8'd24;
  localparam logic [7:0] ProductLenReset   = 8'd34;

  localparam int unsigned NumDesc = 7;
  localparam logic [15:0] DESC_VALUE [NumDesc] = '{
    16'h0100, 16'h0200, 16'h2200, 16'h2100, 16'h0300, 16'h0301, 16'h0302
  };
  localparam logic [15:0] DESC_INDEX [NumDesc] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409
  };
  localparam logic [7:0] DescLenDevice = 8'd18;
  localparam logic [7:0] DescLenConfig = 8'd34;
  localparam logic [7:0] DescLenHid    = 8'd9;
  localparam logic [7:0] DescLenLang   = 8'd4;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic        endpoint_ready;
  } req_t;

  // one queued command; desc_len is only meaningful for ACT_DESC
  typedef struct packed {
    action_e    action;
    logic [2:0] descriptor_id;
    logic [7:0] desc_len;
    logic [5:0] byte_count;
    logic [7:0] reply_byte;
    logic [6:0] device_address;
  } cmd_t;

endpackage

/* sv/usb_hid_control_responder.sv */
`timescale 1ns / 1ps
// Control-request responder for a HID device, with the idle-report timer.
// Each input item is a setup packet, bus reset, frame tick or report-sent
// note (tuser). The front end decodes an item in the cycle it is accepted,
// updates device state and queues at most one command in a four-entry
// queue; items that cause no result (bus reset, most frame ticks) only
// change state. The back end turns each command into results, one per cycle
// unless the output stalls, through a registered output: a descriptor
// request gives up to eight chunks of up to 32 bytes (a full last chunk is
// followed by an empty one), any other request gives one result. Input
// items are taken every cycle while the queue has room, so sustained
// throughput is one result per cycle unless the output stalls. An accepted
// item passes the queue, the command register and the output register.
module usb_hid_control_responder import uhcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] request_type, [15:8] request_code, [31:16] request_value,
  // [47:32] request_index, [63:48] request_length, [64] endpoint_ready
  input  logic [71:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] descriptor_id, [10:3] byte_offset, [16:11] byte_count,
  // [24:17] reply_byte, [31:25] device_address
  output logic [31:0] m_axis_tdata,
  // [2:0] action
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  req_t    req;
  cmd_t    push_cmd, q_cmd;
  logic    accept, push, q_full, q_valid, q_pop;
  action_e out_action;
  logic [2:0] out_id;
  logic [7:0] out_off, out_byte;
  logic [5:0] out_cnt;
  logic [6:0] out_addr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;

  assign req.operation      = op_e'(s_axis_tuser);
  assign req.request_type   = s_axis_tdata[7:0];
  assign req.request_code   = s_axis_tdata[15:8];
  assign req.request_value  = s_axis_tdata[31:16];
  assign req.request_index  = s_axis_tdata[47:32];
  assign req.request_length = s_axis_tdata[63:48];
  assign req.endpoint_ready = s_axis_tdata[64];

  uhcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .req_i       (req),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  uhcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  uhcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_action_o (out_action),
    .out_id_o     (out_id),
    .out_offset_o (out_off),
    .out_count_o  (out_cnt),
    .out_byte_o   (out_byte),
    .out_addr_o   (out_addr),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = out_action;
  assign m_axis_tdata = {out_addr, out_byte, out_cnt, out_off, out_id};

endmodule

/* sv/uhcr_front.sv */
`timescale 1ns / 1ps
module uhcr_front import uhcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       accept_i,
  input  req_t       req_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0] report_len_q, vendor_len_q, product_len_q;
  logic [7:0] config_value_q, config_value_d;
  logic [7:0] idle_rate_q, idle_rate_d;
  logic [7:0] idle_tick_q, idle_tick_d;
  logic [7:0] protocol_q, protocol_d;
  logic [1:0] frame_div_q, frame_div_d;

  logic       desc_hit;
  logic [2:0] desc_id;
  logic [7:0] desc_full_len;
  logic [7:0] len_clamp;
  logic [7:0] desc_len;
  logic [7:0] counter_inc;
  logic       has_result;

  always_comb begin
    desc_hit = 1'b0;
    desc_id  = '0;
    for (int i = NumDesc - 1; i >= 0; i--) begin
      if (req_i.request_value == DESC_VALUE[i] && req_i.request_index == DESC_INDEX[i]) begin
        desc_hit = 1'b1;
        desc_id  = 3'(i);
      end
    end
  end

  always_comb begin
    unique case (desc_id)
      3'd0:    desc_full_len = DescLenDevice;
      3'd1:    desc_full_len = DescLenConfig;
      3'd2:    desc_full_len = report_len_q;
      3'd3:    desc_full_len = DescLenHid;
      3'd4:    desc_full_len = DescLenLang;
      3'd5:    desc_full_len = vendor_len_q;
      default: desc_full_len = product_len_q;
    endcase
  end

  assign len_clamp   = (|req_i.request_length[15:8]) ? 8'hff : req_i.request_length[7:0];
  assign desc_len    = (len_clamp < desc_full_len) ? len_clamp : desc_full_len;
  assign counter_inc = idle_tick_q + 8'd1;

  always_comb begin
    config_value_d = config_value_q;
    idle_rate_d    = idle_rate_q;
    idle_tick_d    = idle_tick_q;
    protocol_d     = protocol_q;
    frame_div_d    = frame_div_q;
    has_result     = 1'b0;
    cmd_o          = '0;
    cmd_o.action   = ACT_STALL;

    unique case (req_i.operation)
      OP_SETUP: begin
        has_result = 1'b1;
        priority if (req_i.request_code == REQ_GET_DESC) begin
          if (desc_hit) begin
            cmd_o.action        = ACT_DESC;
            cmd_o.descriptor_id = desc_id;
            cmd_o.desc_len      = desc_len;
          end
        end else if (req_i.request_code == REQ_SET_ADDRESS) begin
          cmd_o.action         = ACT_ADDR;
          cmd_o.device_address = req_i.request_value[6:0];
        end else if (req_i.request_code == REQ_SET_CONFIG && req_i.request_type == RT_STD_OUT) begin
          config_value_d = req_i.request_value[7:0];
          cmd_o.action   = ACT_ACK;
        end else if (req_i.request_code == REQ_GET_CONFIG && req_i.request_type == RT_STD_IN) begin
          cmd_o.action     = ACT_BYTES;
          cmd_o.byte_count = 6'd1;
          cmd_o.reply_byte = config_value_q;
        end else if (req_i.request_code == REQ_GET_STATUS) begin
          cmd_o.action     = ACT_BYTES;
          cmd_o.byte_count = 6'd2;
        end else if (req_i.request_index == 16'd0 && req_i.request_type == RT_CLASS_IN) begin
          priority if (req_i.request_code == CLS_FETCH_REPORT) begin
            cmd_o.action = ACT_REPORT;
          end else if (req_i.request_code == CLS_FETCH_RATE) begin
            cmd_o.action     = ACT_BYTES;
            cmd_o.byte_count = 6'd1;
            cmd_o.reply_byte = idle_rate_q;
          end else if (req_i.request_code == CLS_FETCH_MODE) begin
            cmd_o.action     = ACT_BYTES;
            cmd_o.byte_count = 6'd1;
            cmd_o.reply_byte = protocol_q;
          end else begin
            cmd_o.action = ACT_STALL;
          end
        end else if (req_i.request_index == 16'd0 && req_i.request_type == RT_CLASS_OUT) begin
          priority if (req_i.request_code == CLS_STORE_REPORT) begin
            cmd_o.action = ACT_ACK;
          end else if (req_i.request_code == CLS_STORE_RATE) begin
            idle_rate_d  = req_i.request_value[15:8];
            idle_tick_d  = '0;
            cmd_o.action = ACT_ACK;
          end else if (req_i.request_code == CLS_STORE_MODE) begin
            protocol_d   = req_i.request_value[7:0];
            cmd_o.action = ACT_ACK;
          end else begin
            cmd_o.action = ACT_STALL;
          end
        end else begin
          cmd_o.action = ACT_STALL;
        end
      end
      OP_BUS_RESET: begin
        config_value_d = '0;
      end
      OP_FRAME: begin
        if (config_value_q != '0 && idle_rate_q != '0) begin
          frame_div_d = frame_div_q + 2'd1;
          // divider wraps to zero on every fourth tick
          if (frame_div_q == 2'd3 && req_i.endpoint_ready) begin
            idle_tick_d = counter_inc;
            if (counter_inc == idle_rate_q) begin
              idle_tick_d  = '0;
              has_result   = 1'b1;
              cmd_o.action = ACT_IDLE;
            end
          end
        end
      end
      OP_REPORT_SENT: begin
        if (config_value_q != '0) idle_tick_d = '0;
      end
      default: ;
    endcase
  end

  assign push_o = accept_i && has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_len_q   <= ReportLenReset;
      vendor_len_q   <= VendorLenReset;
      product_len_q  <= ProductLenReset;
      config_value_q <= '0;
      idle_rate_q    <= IdleRateReset;
      idle_tick_q    <= '0;
      protocol_q     <= ProtocolReset;
      frame_div_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_REPORT_LEN:  report_len_q  <= cfg_data_i;
          CFG_VENDOR_LEN:  vendor_len_q  <= cfg_data_i;
          CFG_PRODUCT_LEN: product_len_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        config_value_q <= config_value_d;
        idle_rate_q    <= idle_rate_d;
        idle_tick_q    <= idle_tick_d;
        protocol_q     <= protocol_d;
        frame_div_q    <= frame_div_d;
      end
    end
  end

endmodule

/* sv/uhcr_queue.sv */
`timescale 1ns / 1ps
module uhcr_queue import uhcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (push_i && !do_pop) count_q <= count_q + QCntW'(1);
      else if (!push_i && do_pop) count_q <= count_q - QCntW'(1);
    end
  end

endmodule

/* sv/uhcr_back.sv */
`timescale 1ns / 1ps
module uhcr_back import uhcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output action_e     out_action_o,
  output logic [2:0]  out_id_o,
  output logic [7:0]  out_offset_o,
  output logic [5:0]  out_count_o,
  output logic [7:0]  out_byte_o,
  output logic [6:0]  out_addr_o,
  output logic        out_last_o
);

  logic                 act_v_q;
  cmd_t                 act_q;
  logic [7:0]           rem_q;
  logic [7:0]           off_q;
  logic [ChunkIdxW-1:0] k_q;

  logic                 out_v_q;
  action_e              o_action_q;
  logic [2:0]           o_id_q;
  logic [7:0]           o_off_q;
  logic [5:0]           o_cnt_q;
  logic [7:0]           o_byte_q;
  logic [6:0]           o_addr_q;
  logic                 o_last_q;

  logic                 is_desc;
  logic [5:0]           chunk_n;
  logic [7:0]           rem_next;
  logic                 more;
  logic                 gen, gen_last;

  assign is_desc  = (act_q.action == ACT_DESC);
  assign chunk_n  = (rem_q >= 8'(PktBytes)) ? 6'(PktBytes) : rem_q[5:0];
  assign rem_next = rem_q - 8'(chunk_n);
  // a full last chunk is followed by a zero-length one
  assign more     = (rem_next != '0) || (chunk_n == 6'(PktBytes));
  assign gen_last = !is_desc || !more || (k_q == ChunkIdxW'(MaxChunks - 1));
  assign gen      = act_v_q && (!out_v_q || out_ready_i);
  assign q_pop_o  = q_valid_i && (!act_v_q || (gen && gen_last));

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      act_q <= q_cmd_i;
    end
    if (q_pop_o) begin
      rem_q <= q_cmd_i.desc_len;
      off_q <= '0;
      k_q   <= '0;
    end else if (gen) begin
      rem_q <= rem_next;
      off_q <= off_q + 8'(chunk_n);
      k_q   <= k_q + ChunkIdxW'(1);
    end
    if (gen) begin
      o_action_q <= act_q.action;
      o_last_q   <= gen_last;
      if (is_desc) begin
        o_id_q   <= act_q.descriptor_id;
        o_off_q  <= off_q;
        o_cnt_q  <= chunk_n;
        o_byte_q <= '0;
        o_addr_q <= '0;
      end else begin
        o_id_q   <= '0;
        o_off_q  <= '0;
        o_cnt_q  <= act_q.byte_count;
        o_byte_q <= act_q.reply_byte;
        o_addr_q <= act_q.device_address;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (q_pop_o) act_v_q <= 1'b1;
      else if (gen && gen_last) act_v_q <= 1'b0;
      if (gen) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_action_o = o_action_q;
  assign out_id_o     = o_id_q;
  assign out_offset_o = o_off_q;
  assign out_count_o  = o_cnt_q;
  assign out_byte_o   = o_byte_q;
  assign out_addr_o   = o_addr_q;
  assign out_last_o   = o_last_q;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import uhcr_pkg::*;

  typedef struct packed {
    action_e    action;
    logic [2:0] descriptor_id;
    logic [7:0] byte_offset;
    logic [5:0] byte_count;
    logic [7:0] reply_byte;
    logic [6:0] device_address;
    logic       is_last;
  } resp_t;

  // fixed set: want is typed in and replaces the predicted reply
  typedef struct packed {
    req_t  req;
    logic  fixed;
    resp_t want;
  } stim_row_t;

  localparam int unsigned RowCount    = 27;
  localparam int unsigned PhaseCount  = 4;
  localparam int unsigned PhaseItems  = 46;
  localparam int unsigned BurstItems  = 8;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned LongHold    = 80;
  localparam int unsigned ChunkBytes  = 32;
  localparam int unsigned ReplyMax    = 8;

  localparam logic [2:0] DescIdHid  = 3'd3;
  localparam int unsigned NoMatch   = 7;
  localparam logic [15:0] DescValue [7] = '{
    16'h0100, 16'h0200, 16'h2200, 16'h2100, 16'h0300, 16'h0301, 16'h0302
  };
  localparam logic [15:0] DescIndex [7] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409
  };

  localparam resp_t NoReply = '{ACT_NONE, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b0};

  localparam stim_row_t Plan [RowCount] = '{
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 1'b0},
      1'b1, '{ACT_BYTES, 3'd0, 8'd0, 6'd2, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001, 1'b0},
      1'b1, '{ACT_BYTES, 3'd0, 8'd0, 6'd1, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_CLASS_IN, CLS_FETCH_RATE, 16'h0000, 16'h0000, 16'h0001, 1'b0},
      1'b1, '{ACT_BYTES, 3'd0, 8'd0, 6'd1, 8'd125, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_CLASS_IN, CLS_FETCH_MODE, 16'h0000, 16'h0000, 16'h0001, 1'b0},
      1'b1, '{ACT_BYTES, 3'd0, 8'd0, 6'd1, 8'd1, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_CLASS_IN, CLS_FETCH_REPORT, 16'h0100, 16'h0000, 16'h0008, 1'b0},
      1'b1, '{ACT_REPORT, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, 8'hff, REQ_SET_ADDRESS, 16'hffff, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{ACT_ADDR, 3'd0, 8'd0, 6'd0, 8'd0, 7'h7f, 1'b1}},
    '{'{OP_SETUP, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 1'b1},
      1'b1, '{ACT_STALL, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    // descriptor lookups: no match, every table entry but 0300, length clamping
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h0303, 16'h0000, 16'h00ff, 1'b0},
      1'b1, '{ACT_STALL, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h0100, 16'h0000, 16'hffff, 1'b0},
      1'b0, NoReply},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h0200, 16'h0000, 16'h00ff, 1'b0},
      1'b0, NoReply},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h2200, 16'h0000, 16'h0100, 1'b0},
      1'b0, NoReply},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h2100, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{ACT_DESC, DescIdHid, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h0301, 16'h0409, 16'hffff, 1'b0},
      1'b0, NoReply},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h0302, 16'h0409, 16'h0020, 1'b0},
      1'b0, NoReply},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h0100, 16'h0409, 16'h00ff, 1'b0},
      1'b1, '{ACT_STALL, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    // HID requests only answer on index zero
    '{'{OP_SETUP, RT_CLASS_IN, CLS_FETCH_RATE, 16'h0000, 16'h0001, 16'h0001, 1'b0},
      1'b1, '{ACT_STALL, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_STD_OUT, REQ_SET_CONFIG, 16'h00ff, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{ACT_ACK, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_STD_IN, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001, 1'b0},
      1'b0, NoReply},
    '{'{OP_SETUP, RT_CLASS_OUT, CLS_STORE_RATE, 16'h0100, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{ACT_ACK, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_CLASS_OUT, CLS_STORE_MODE, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{ACT_ACK, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_SETUP, RT_CLASS_OUT, CLS_STORE_REPORT, 16'h0200, 16'h0000, 16'h0001, 1'b0},
      1'b1, '{ACT_ACK, 3'd0, 8'd0, 6'd0, 8'd0, 7'd0, 1'b1}},
    '{'{OP_REPORT_SENT, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      1'b0, NoReply},
    // idle rate is one now: the fourth tick sends an idle report
    '{'{OP_FRAME, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NoReply},
    '{'{OP_FRAME, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NoReply},
    '{'{OP_FRAME, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NoReply},
    '{'{OP_FRAME, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NoReply},
    '{'{OP_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NoReply}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  usb_hid_control_responder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // device state as the responder should hold it
  logic [7:0] report_len   = 8'd63;
  logic [7:0] vendor_len   = 8'd24;
  logic [7:0] product_len  = 8'd34;
  logic [7:0] dev_config   = 8'd0;
  logic [7:0] idle_rate    = 8'd125;
  logic [7:0] idle_tick    = 8'd0;
  logic [7:0] protocol_mode = 8'd1;
  logic [1:0] frame_phase  = 2'd0;

  resp_t       reply_buf [ReplyMax];
  resp_t       replies_due [$];
  int unsigned mismatch_count = 0;

  logic  row_fixed = 1'b0;
  resp_t row_want  = NoReply;
  logic  calm      = 1'b0;
  logic  sink_hold = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic resp_t one_reply(input action_e act, input logic [5:0] cnt,
                                      input logic [7:0] rb, input logic [6:0] addr);
    resp_t r;
    r = '{act, 3'd0, 8'd0, cnt, rb, addr, 1'b1};
    return r;
  endfunction

  function automatic int unsigned desc_size(input int unsigned id);
    case (id)
      0:       return 18;
      1:       return 34;
      2:       return report_len;
      3:       return 9;
      4:       return 4;
      5:       return vendor_len;
      default: return product_len;
    endcase
  endfunction

  // Updates the device state for one item, fills reply_buf, returns the reply count.
  function automatic int unsigned predict_reply(input req_t r);
    int unsigned id, remain, n, off, k;
    logic        more;
    id = NoMatch;
    remain = 0;
    n = 0;
    off = 0;
    k = 0;
    more = 1'b0;
    case (r.operation)
      OP_BUS_RESET: begin
        dev_config = 8'd0;
        return 0;
      end
      OP_REPORT_SENT: begin
        if (dev_config != 8'd0) idle_tick = 8'd0;
        return 0;
      end
      OP_FRAME: begin
        if (dev_config != 8'd0 && idle_rate != 8'd0) begin
          frame_phase = frame_phase + 2'd1;
          if (frame_phase == 2'd0 && r.endpoint_ready) begin
            idle_tick = idle_tick + 8'd1;
            if (idle_tick == idle_rate) begin
              idle_tick = 8'd0;
              reply_buf[0] = one_reply(ACT_IDLE, 6'd0, 8'd0, 7'd0);
              return 1;
            end
          end
        end
        return 0;
      end
      default: ;
    endcase

    if (r.request_code == REQ_GET_DESC) begin
      for (int i = 0; i < 7; i++) begin
        if (id == NoMatch && DescValue[i] == r.request_value &&
            DescIndex[i] == r.request_index) id = i;
      end
      if (id == NoMatch) begin
        reply_buf[0] = one_reply(ACT_STALL, 6'd0, 8'd0, 7'd0);
        return 1;
      end
      remain = (r.request_length > 16'd255) ? 255 : r.request_length;
      if (remain > desc_size(id)) remain = desc_size(id);
      forever begin
        n = (remain < ChunkBytes) ? remain : ChunkBytes;
        remain -= n;
        more = (remain != 0) || (n == ChunkBytes);
        reply_buf[k] = '{ACT_DESC, id[2:0], off[7:0], n[5:0], 8'd0, 7'd0,
                         !(more && (k + 1 < ReplyMax))};
        k++;
        off += n;
        if (!more || k >= ReplyMax) break;
      end
      return k;
    end
    if (r.request_code == REQ_SET_ADDRESS) begin
      reply_buf[0] = one_reply(ACT_ADDR, 6'd0, 8'd0, r.request_value[6:0]);
      return 1;
    end
    if (r.request_code == REQ_SET_CONFIG && r.request_type == RT_STD_OUT) begin
      dev_config = r.request_value[7:0];
      reply_buf[0] = one_reply(ACT_ACK, 6'd0, 8'd0, 7'd0);
      return 1;
    end
    if (r.request_code == REQ_GET_CONFIG && r.request_type == RT_STD_IN) begin
      reply_buf[0] = one_reply(ACT_BYTES, 6'd1, dev_config, 7'd0);
      return 1;
    end
    if (r.request_code == REQ_GET_STATUS) begin
      reply_buf[0] = one_reply(ACT_BYTES, 6'd2, 8'd0, 7'd0);
      return 1;
    end
    reply_buf[0] = one_reply(ACT_STALL, 6'd0, 8'd0, 7'd0);
    if (r.request_index == 16'd0) begin
      if (r.request_type == RT_CLASS_IN) begin
        case (r.request_code)
          CLS_FETCH_REPORT: reply_buf[0] = one_reply(ACT_REPORT, 6'd0, 8'd0, 7'd0);
          CLS_FETCH_RATE:   reply_buf[0] = one_reply(ACT_BYTES, 6'd1, idle_rate, 7'd0);
          CLS_FETCH_MODE:   reply_buf[0] = one_reply(ACT_BYTES, 6'd1, protocol_mode, 7'd0);
          default: ;
        endcase
      end else if (r.request_type == RT_CLASS_OUT) begin
        case (r.request_code)
          CLS_STORE_REPORT: reply_buf[0] = one_reply(ACT_ACK, 6'd0, 8'd0, 7'd0);
          CLS_STORE_RATE: begin
            idle_rate = r.request_value[15:8];
            idle_tick = 8'd0;
            reply_buf[0] = one_reply(ACT_ACK, 6'd0, 8'd0, 7'd0);
          end
          CLS_STORE_MODE: begin
            protocol_mode = r.request_value[7:0];
            reply_buf[0] = one_reply(ACT_ACK, 6'd0, 8'd0, 7'd0);
          end
          default: ;
        endcase
      end
    end
    return 1;
  endfunction

  task automatic check_reply();
    resp_t got, want;
    got.action         = action_e'(m_axis_tuser);
    got.descriptor_id  = m_axis_tdata[2:0];
    got.byte_offset    = m_axis_tdata[10:3];
    got.byte_count     = m_axis_tdata[16:11];
    got.reply_byte     = m_axis_tdata[24:17];
    got.device_address = m_axis_tdata[31:25];
    got.is_last        = m_axis_tlast;
    if (replies_due.size() == 0) begin
      log_mismatch($sformatf("result with none pending, action %0d", got.action));
    end else begin
      want = replies_due.pop_front();
      if (got.action != want.action)
        log_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
      if (got.descriptor_id != want.descriptor_id)
        log_mismatch($sformatf("descriptor_id %0d, want %0d",
                               got.descriptor_id, want.descriptor_id));
      if (got.byte_offset != want.byte_offset)
        log_mismatch($sformatf("byte_offset %0d, want %0d",
                               got.byte_offset, want.byte_offset));
      if (got.byte_count != want.byte_count)
        log_mismatch($sformatf("byte_count %0d, want %0d",
                               got.byte_count, want.byte_count));
      if (got.reply_byte != want.reply_byte)
        log_mismatch($sformatf("reply_byte %0d, want %0d",
                               got.reply_byte, want.reply_byte));
      if (got.device_address != want.device_address)
        log_mismatch($sformatf("device_address %0d, want %0d",
                               got.device_address, want.device_address));
      if (got.is_last != want.is_last)
        log_mismatch($sformatf("tlast %0b, want %0b", got.is_last, want.is_last));
    end
  endtask

  // checks results, then predicts for the item taken at the same edge
  always @(posedge clk_i) begin : scoreboard
    req_t        taken;
    int unsigned n;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (s_axis_tvalid && s_axis_tready) begin
        taken.operation      = op_e'(s_axis_tuser);
        taken.request_type   = s_axis_tdata[7:0];
        taken.request_code   = s_axis_tdata[15:8];
        taken.request_value  = s_axis_tdata[31:16];
        taken.request_index  = s_axis_tdata[47:32];
        taken.request_length = s_axis_tdata[63:48];
        taken.endpoint_ready = s_axis_tdata[64];
        n = predict_reply(taken);
        if (row_fixed) replies_due.push_back(row_want);
        else for (int k = 0; k < n; k++) replies_due.push_back(reply_buf[k]);
      end
    end
  end

  // result side: short random stalls, or one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        m_axis_tready = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        sink_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // leaves tvalid high; the caller lowers it for a gap or at the end
  task automatic send_item(input req_t r, input logic fixed, input resp_t want);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, r.endpoint_ready, r.request_length, r.request_index,
                     r.request_value, r.request_code, r.request_type};
    s_axis_tuser  = r.operation;
    row_fixed     = fixed;
    row_want      = want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REPORT_LEN:  report_len = val;
      CFG_VENDOR_LEN:  vendor_len = val;
      CFG_PRODUCT_LEN: product_len = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // mostly well-formed requests with random content, frame ticks and other events, some noise
  function automatic req_t random_request();
    req_t        r;
    int unsigned sel, pick;
    r.operation      = OP_SETUP;
    r.request_type   = 8'($urandom);
    r.request_code   = 8'($urandom);
    r.request_value  = 16'($urandom);
    r.request_index  = 16'($urandom);
    r.request_length = 16'($urandom);
    r.endpoint_ready = 1'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      r.request_code = REQ_GET_DESC;
      pick = $urandom_range(0, 7);
      if (pick < 7) begin
        r.request_value = DescValue[pick];
        if ($urandom_range(0, 9) != 0) r.request_index = DescIndex[pick];
      end
      case ($urandom_range(0, 3))
        0:       r.request_length = 16'($urandom_range(0, 40));
        1:       r.request_length = 16'($urandom_range(0, 300));
        2:       r.request_length = 16'(32 * $urandom_range(0, 8));
        default: ;
      endcase
    end else if (sel < 32) begin
      r.request_type = RT_CLASS_OUT;
      r.request_code = CLS_STORE_RATE;
      if ($urandom_range(0, 9) != 0) r.request_index = 16'd0;
      if ($urandom_range(0, 9) != 0) r.request_value[15:8] = 8'($urandom_range(0, 3));
    end else if (sel < 38) begin
      r.request_type = RT_STD_OUT;
      r.request_code = REQ_SET_CONFIG;
      r.request_value[7:0] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    end else if (sel < 50) begin
      r.request_index = 16'd0;
      case ($urandom_range(0, 7))
        0: r.request_code = REQ_GET_STATUS;
        1: r.request_code = REQ_SET_ADDRESS;
        2: begin
          r.request_type = RT_STD_IN;
          r.request_code = REQ_GET_CONFIG;
        end
        3: begin
          r.request_type = RT_CLASS_IN;
          r.request_code = CLS_FETCH_REPORT;
        end
        4: begin
          r.request_type = RT_CLASS_IN;
          r.request_code = CLS_FETCH_RATE;
        end
        5: begin
          r.request_type = RT_CLASS_IN;
          r.request_code = CLS_FETCH_MODE;
        end
        6: begin
          r.request_type = RT_CLASS_OUT;
          r.request_code = CLS_STORE_REPORT;
        end
        default: begin
          r.request_type = RT_CLASS_OUT;
          r.request_code = CLS_STORE_MODE;
        end
      endcase
    end else if (sel < 78) begin
      r.operation = OP_FRAME;
      r.endpoint_ready = ($urandom_range(0, 4) != 0);
    end else if (sel < 83) begin
      r.operation = OP_REPORT_SENT;
    end else if (sel < 86) begin
      r.operation = OP_BUS_RESET;
    end else begin
      r.operation = op_e'(2'($urandom_range(0, 3)));
    end
    return r;
  endfunction

  initial begin
    logic [7:0] lens [PhaseCount][3];
    req_t       fill;
    lens = '{'{8'd0, 8'd255, 8'd32}, '{8'd255, 8'd0, 8'd64},
             '{8'd224, 8'd96, 8'd1}, '{8'd0, 8'd0, 8'd0}};
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_REPORT_LEN;
    cfg_data_i    = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_SETUP;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < RowCount; i++) begin
      send_item(Plan[i].req, Plan[i].fixed, Plan[i].want);
      sender_gap();
    end
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == PhaseCount - 1) begin
        lens[p] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255))};
        calm = 1'b1;
      end
      write_reg(CFG_REPORT_LEN, lens[p][0]);
      write_reg(CFG_VENDOR_LEN, lens[p][1]);
      write_reg(CFG_PRODUCT_LEN, lens[p][2]);
      if (p == 1) begin
        // long result stall while long descriptor replies keep coming
        sink_hold = 1'b1;
        fill = '{OP_SETUP, RT_STD_IN, REQ_GET_DESC, 16'h0200, 16'h0000, 16'h00ff, 1'b0};
        for (int i = 0; i < BurstItems; i++) send_item(fill, 1'b0, NoReply);
      end
      for (int i = 0; i < PhaseItems; i++) begin
        send_item(random_request(), 1'b0, NoReply);
        sender_gap();
      end
      drain();
    end

    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
